[design/fwcs_pkg.sv]
package fwcs_pkg;

  localparam int unsigned DefPositions = 256;
  localparam int unsigned EpochW       = 6;
  localparam int unsigned CfgAddrW     = 3;

  localparam logic CfgMaxValue     = 1'b0;
  localparam logic CfgNonzeroCount = 1'b1;

  typedef struct packed {
    logic [7:0]  position;
    logic [15:0] challenge_value;
    logic        last;
  } result_t;

endpackage

[design/fwcs_out_buf.sv]
module fwcs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fwcs_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fwcs_pkg::result_t out_data_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  fwcs_pkg::result_t main_q, main_d;
  fwcs_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop = main_v_q && !out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push_i;
        main_d   = push_data_i;
      end
    end else if (!main_v_q) begin
      main_v_d = push_i;
      main_d   = push_data_i;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("result pushed into a full buffer");

  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without an output entry");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && out_stall_i) |=> (main_v_q && $stable(main_q)))
    else $error("stalled result changed");

endmodule

[design/fixed_weight_challenge_sampler.sv]
// Fixed-weight challenge sampler.
// Input channel: one extendable-output byte per transfer (in_valid_i, in_stall_o, xof_byte_i).
// Output channel: one (position, challenge_value, last) result per accepted position/value
// pair (out_valid_o, out_stall_i). last marks the pair that completes nonzero_count.
// Configuration: APB-style port, max_value at address 0, nonzero_count at address 4.
// Throughput: one byte per cycle while in_stall_o is low. An accepted value sample pushes
// its result into the output buffer. A position sample reads the taken-tag memory; the read
// returns in the next cycle and resolves the phase for the byte arriving then: no bubble.
// Taken flags are epoch tags in one synchronous memory of POSITIONS entries; a challenge
// ends by advancing the epoch. After reset, and after every 2**EpochW-1 challenges, a
// clearing pass writes every entry, one per cycle; in_stall_o is high during the pass.
// The output has a register plus a skid entry: bytes keep being taken while one result
// waits under out_stall_i. in_stall_o rises when both are full or in a clearing pass.
// Reset clears all control state, sets max_value and nonzero_count to one, and starts the
// clearing pass.
module fixed_weight_challenge_sampler #(
  parameter int unsigned POSITIONS = fwcs_pkg::DefPositions
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    xof_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    position_o,
  output logic [15:0]                   challenge_value_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwcs_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(POSITIONS);
  localparam int unsigned EW = fwcs_pkg::EpochW;
  localparam logic        PTwoBytes = (AW > 8);
  localparam logic [AW:0] PosLimit  = (AW + 1)'(POSITIONS);
  localparam logic [AW-1:0] SweepLast = AW'(POSITIONS - 1);
  localparam logic [EW-1:0] EpFirst   = EW'(1);
  localparam logic [EW-1:0] EpMax     = {EW{1'b1}};

  logic [EW-1:0] tag_mem [POSITIONS];
  logic [EW-1:0] rdata_q;

  logic [15:0]   max_q;
  logic [8:0]    nz_q;
  logic [7:0]    acc_q;
  logic          gath_q;
  logic          phase_q;
  logic [AW-1:0] held_q;
  logic [8:0]    cnt_q;
  logic [EW-1:0] ep_q;
  logic          pend_q;
  logic          pend_ok_q;
  logic [AW-1:0] pend_pos_q;
  logic          sweep_q;
  logic [AW-1:0] sw_cnt_q;

  logic          xfer_in;
  logic          dec_acc;
  logic          phase_eff;
  logic [AW-1:0] held_eff;
  logic [15:0]   smear_1;
  logic [15:0]   smear_2;
  logic [15:0]   smear_4;
  logic [15:0]   smear;
  logic [15:0]   vmask;
  logic          need2;
  logic          complete;
  logic [15:0]   raw;
  logic [AW-1:0] sample_pos;
  logic          inrange;
  logic [15:0]   vsample;
  logic          pos_done;
  logic          val_acc;
  logic [8:0]    cnt_inc;
  logic          last;
  logic          cfg_wr;
  logic          buf_full;
  fwcs_pkg::result_t res;
  fwcs_pkg::result_t out_data;

  assign xfer_in   = in_valid_i && !in_stall_o;
  assign dec_acc   = pend_ok_q && (rdata_q != ep_q);
  assign phase_eff = pend_q ? dec_acc : phase_q;
  assign held_eff  = pend_q ? pend_pos_q : held_q;

  assign smear_1 = max_q | (max_q >> 1);
  assign smear_2 = smear_1 | (smear_1 >> 2);
  assign smear_4 = smear_2 | (smear_2 >> 4);
  assign smear   = smear_4 | (smear_4 >> 8);
  assign vmask   = smear | 16'h0001;

  assign need2      = phase_eff ? (|max_q[15:8]) : PTwoBytes;
  assign complete   = gath_q || !need2;
  assign raw        = gath_q ? {xof_byte_i, acc_q} : {8'h00, xof_byte_i};
  assign sample_pos = raw[AW-1:0];
  assign inrange    = {1'b0, sample_pos} < PosLimit;
  assign vsample    = raw & vmask;

  assign pos_done = xfer_in && !phase_eff && complete;
  assign val_acc  = xfer_in && phase_eff && complete && (vsample != 16'h0000)
                    && (vsample <= max_q);
  assign cnt_inc  = cnt_q + 9'd1;
  assign last     = cnt_inc >= nz_q;

  assign res.position        = 8'(held_eff);
  assign res.challenge_value = max_q - vsample;
  assign res.last            = last;

  always_ff @(posedge clk_i) begin
    if (pos_done && inrange) begin
      rdata_q <= tag_mem[sample_pos];
    end
    if (sweep_q) begin
      tag_mem[sw_cnt_q] <= '0;
    end else if (val_acc) begin
      tag_mem[held_eff] <= ep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 8'h00;
      gath_q     <= 1'b0;
      phase_q    <= 1'b0;
      held_q     <= '0;
      cnt_q      <= 9'd0;
      ep_q       <= EpFirst;
      pend_q     <= 1'b0;
      pend_ok_q  <= 1'b0;
      pend_pos_q <= '0;
      sweep_q    <= 1'b1;
      sw_cnt_q   <= '0;
    end else begin
      if (xfer_in) begin
        if (complete) begin
          gath_q <= 1'b0;
          acc_q  <= 8'h00;
        end else begin
          gath_q <= 1'b1;
          acc_q  <= xof_byte_i;
        end
      end
      if (val_acc) begin
        phase_q <= 1'b0;
      end else if (pend_q) begin
        phase_q <= dec_acc;
      end
      if (pend_q && dec_acc) begin
        held_q <= pend_pos_q;
      end
      pend_q     <= pos_done;
      pend_ok_q  <= inrange;
      pend_pos_q <= sample_pos;
      if (val_acc) begin
        cnt_q <= last ? 9'd0 : cnt_inc;
      end
      if (sweep_q) begin
        if (sw_cnt_q == SweepLast) begin
          sweep_q  <= 1'b0;
          sw_cnt_q <= '0;
        end else begin
          sw_cnt_q <= sw_cnt_q + AW'(1);
        end
      end else if (val_acc && last) begin
        if (ep_q == EpMax) begin
          ep_q    <= EpFirst;
          sweep_q <= 1'b1;
        end else begin
          ep_q <= ep_q + EpFirst;
        end
      end
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'd1;
      nz_q  <= 9'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fwcs_pkg::CfgMaxValue:     max_q <= pwdata[15:0];
        fwcs_pkg::CfgNonzeroCount: nz_q  <= pwdata[8:0];
        default:                   max_q <= max_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fwcs_pkg::CfgMaxValue:     prdata = {16'h0000, max_q};
      fwcs_pkg::CfgNonzeroCount: prdata = {23'h000000, nz_q};
      default:                   prdata = 32'h00000000;
    endcase
  end

  assign pready = 1'b1;

  fwcs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (val_acc),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign in_stall_o        = sweep_q || buf_full;
  assign position_o        = out_data.position;
  assign challenge_value_o = out_data.challenge_value;
  assign last_o            = out_data.last;

  a_no_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !pend_q)
    else $error("tag lookup pending during clearing pass");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ep_q != '0)
    else $error("current epoch collides with cleared tag");

  a_wrap_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_acc && last && !sweep_q && (ep_q == EpMax)) |=> (sweep_q && (ep_q == EpFirst)))
    else $error("epoch wrap did not start a clearing pass");

endmodule
